// ===== design/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property under clock clk, disabled while reset is low.
`define CHK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`endif

// ===== design/ffha_pkg.sv =====
// Types and codes for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_NOFIT   = 3'd1;
	localparam logic [2:0] ST_ZERO    = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_LSCAN,
		S_FSCAN,
		S_FREAD,
		S_DECIDE,
		S_SHIFT,
		S_WRITE,
		S_DONE
	} state_t;
endpackage

// ===== design/ffha_req_if.sv =====
// Request channel interface of the heap allocator.
// Depends on nothing.
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] request_size;
	logic [31:0] block_address;
	modport source (output valid, kind, request_size, block_address, input ready);
	modport sink (input valid, kind, request_size, block_address, output ready);
endinterface

// ===== design/ffha_rsp_if.sv =====
// Response channel interface of the heap allocator.
// Depends on nothing.
interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] payload_address;
	logic [15:0] usable_size;
	modport source (output valid, status, payload_address, usable_size, input ready);
	modport sink (input valid, status, payload_address, usable_size, output ready);
endinterface

// ===== design/first_fit_heap_allocator_core.sv =====
// First-fit heap allocator top level: sequencer, free table and live table.
// Depends on ffha_pkg, ffha_req_if, ffha_rsp_if and assert_macros.svh.
//
// One request is taken at a time; the core drops ready until the response word
// leaves. After reset the free table is swept once, before the first request
// is taken. A request scans the live table one slot a cycle; an alloc or free
// request then scans the free table an extent at a time (read, then compare),
// then shifts entries (a read, then a write, per entry) when an extent is
// inserted or dropped. The free table has one registered read port.
`include "assert_macros.svh"
module first_fit_heap_allocator_core #(
	parameter int HEAP_BYTES   = 65536,
	parameter int HEADER_BYTES = 12,
	parameter int FREE_SLOTS   = 32,
	parameter int LIVE_SLOTS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	ffha_req_if.sink    req,
	ffha_rsp_if.source  rsp
);
	localparam int FW = $clog2(FREE_SLOTS);
	localparam int LW = $clog2(LIVE_SLOTS);
	// Wide enough for any rounded request plus header, and for the heap offsets.
	localparam int OW = ($clog2(HEAP_BYTES) + 1 > 18) ? $clog2(HEAP_BYTES) + 1 : 18;
	localparam logic [OW-1:0] HDR = OW'(HEADER_BYTES);
	localparam logic [OW-1:0] INIT_LEN = OW'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [FW:0]   CNT_ONE = (FW+1)'(1);
	localparam logic [FW-1:0] IDX_ONE = FW'(1);
	localparam logic [LW:0]   LI_ONE = (LW+1)'(1);

	ffha_pkg::state_t state_q, state_d;

	logic [31:0]   base_q;
	logic [OW-1:0] fs_mem [FREE_SLOTS];
	logic [OW-1:0] fl_mem [FREE_SLOTS];
	logic [OW-1:0] ls_mem [LIVE_SLOTS];
	logic [OW-1:0] ll_mem [LIVE_SLOTS];
	logic [LIVE_SLOTS-1:0] lv_q;
	logic [FW:0]   fcnt_q;

	logic [1:0]    kind_q;
	logic [OW-1:0] aligned_q, needed_q, off_q;
	logic          addr_ok_q;
	logic [LW:0]   li_q;
	logic          lhit_q, lfree_q;
	logic [LW-1:0] lslot_q, lempty_q;
	logic [FW:0]   fi_q;
	logic          ffound_q;
	logic [OW-1:0] fs_rd_q, fl_rd_q, ps_q, pl_q, len_q;
	logic          pvalid_q;
	logic [FW:0]   sh_q;
	logic          sh_up_q;
	logic [2:0]    st_q;
	logic [31:0]   pa_q;
	logic [15:0]   us_q;
	logic          rvalid_q;

	// Memory port drive, from the sequencer.
	logic          fwe;
	logic [FW-1:0] fwa, fra;
	logic [OW-1:0] fws, fwl;

	// Decision, computed on the cycle the chosen extent sits in fs_rd_q.
	logic          lv_set, lv_clr, l_wr, fcnt_inc, fcnt_dec, sh_up_d;
	logic [OW-1:0] l_len;
	logic [FW:0]   sh_q_d;
	logic [2:0]    st_d;
	logic [31:0]   pa_d;
	logic [15:0]   us_d;
	logic          dw_we;
	logic [FW-1:0] dw_a;
	logic [OW-1:0] dw_s, dw_l;
	logic          d_shift;
	logic          wprev, wnext;
	logic [OW-1:0] rem;

	logic sh_phase_q;

	logic [31:0] off_full;
	assign off_full = req.block_address - base_q - 32'(HEADER_BYTES);

	logic fscan_done;
	assign fscan_done = (fi_q >= fcnt_q);

	always_ff @(posedge clk) begin
		if (fwe) begin
			fs_mem[fwa] <= fws;
			fl_mem[fwa] <= fwl;
		end
		fs_rd_q <= fs_mem[fra];
		fl_rd_q <= fl_mem[fra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ffha_pkg::S_INIT;
			base_q   <= '0;
			lv_q     <= '0;
			fcnt_q   <= (FW+1)'(1);
			rvalid_q <= 1'b0;
			sh_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (rsp.valid && rsp.ready) begin
				rvalid_q <= 1'b0;
			end
			case (state_q)
				ffha_pkg::S_INIT: begin
					sh_q <= sh_q + CNT_ONE;
				end
				ffha_pkg::S_IDLE: begin
					if (req.valid) begin
						kind_q    <= req.kind;
						aligned_q <= OW'(({1'b0, req.request_size} + 17'd3) & 17'h1fffc);
						needed_q  <= OW'(({1'b0, req.request_size} + 17'd3) & 17'h1fffc) + HDR;
						off_q     <= off_full[OW-1:0];
						addr_ok_q <= (off_full >> OW) == 32'd0;
						li_q      <= '0;
						lhit_q    <= 1'b0;
						lfree_q   <= 1'b0;
						fi_q      <= '0;
						ffound_q  <= 1'b0;
						pvalid_q  <= 1'b0;
					end
				end
				ffha_pkg::S_LSCAN: begin
					li_q <= li_q + LI_ONE;
					if (!lv_q[li_q[LW-1:0]] && !lfree_q) begin
						lfree_q  <= 1'b1;
						lempty_q <= li_q[LW-1:0];
					end
					if (addr_ok_q && lv_q[li_q[LW-1:0]] && ls_mem[li_q[LW-1:0]] == off_q
					    && !lhit_q) begin
						lhit_q  <= 1'b1;
						lslot_q <= li_q[LW-1:0];
						len_q   <= ll_mem[li_q[LW-1:0]];
					end
				end
				ffha_pkg::S_FREAD: begin
					// Hold the index at the table end so it names the insert slot.
					if (!fscan_done) fi_q <= fi_q + CNT_ONE;
				end
				ffha_pkg::S_FSCAN: begin
					// Extent fi_q-1 is in fs_rd_q/fl_rd_q.
					if (state_d == ffha_pkg::S_FREAD) begin
						pvalid_q <= 1'b1;
						ps_q     <= fs_rd_q;
						pl_q     <= fl_rd_q;
					end else begin
						ffound_q <= 1'b1;
						fi_q     <= fi_q - CNT_ONE;
					end
				end
				ffha_pkg::S_DECIDE: begin
					sh_q    <= sh_q_d;
					sh_up_q <= sh_up_d;
					st_q    <= st_d;
					pa_q    <= pa_d;
					us_q    <= us_d;
					if (lv_set)   lv_q[lempty_q] <= 1'b1;
					if (lv_clr)   lv_q[lslot_q]  <= 1'b0;
					if (l_wr) begin
						ls_mem[lempty_q] <= fs_rd_q;
						ll_mem[lempty_q] <= l_len;
					end
					fcnt_q <= fcnt_q + (FW+1)'(fcnt_inc) - (FW+1)'(fcnt_dec);
				end
				ffha_pkg::S_SHIFT: begin
					// Advance once the entry has been written.
					if (sh_phase_q) sh_q <= sh_up_q ? sh_q - CNT_ONE : sh_q + CNT_ONE;
				end
				ffha_pkg::S_DONE: begin
					if (!rvalid_q) rvalid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		lv_set = 1'b0; lv_clr = 1'b0; l_wr = 1'b0; fcnt_inc = 1'b0; fcnt_dec = 1'b0;
		sh_up_d = 1'b0; l_len = fl_rd_q; sh_q_d = fi_q; st_d = ffha_pkg::ST_UNKNOWN;
		pa_d = '0; us_d = '0; dw_we = 1'b0; dw_a = fi_q[FW-1:0]; dw_s = fs_rd_q;
		dw_l = fl_rd_q; d_shift = 1'b0;
		rem = fl_rd_q - needed_q;
		wprev = pvalid_q && (ps_q + HDR + pl_q == off_q);
		wnext = ffound_q && (off_q + HDR + len_q == fs_rd_q);
		case (kind_q)
			ffha_pkg::KIND_ALLOC: begin
				if (aligned_q == '0) begin
					st_d = ffha_pkg::ST_ZERO;
				end else if (!ffound_q) begin
					st_d = ffha_pkg::ST_NOFIT;
				end else if (!lfree_q) begin
					st_d = ffha_pkg::ST_FULL;
				end else begin
					st_d = ffha_pkg::ST_DONE; lv_set = 1'b1; l_wr = 1'b1;
					if (rem <= HDR + OW'(4)) begin
						l_len = fl_rd_q; fcnt_dec = 1'b1; d_shift = 1'b1;
					end else begin
						l_len = aligned_q; dw_we = 1'b1;
						dw_s = fs_rd_q + needed_q; dw_l = rem;
					end
					pa_d = base_q + 32'(fs_rd_q) + 32'(HEADER_BYTES);
					us_d = l_len[15:0];
				end
			end
			ffha_pkg::KIND_FREE: begin
				if (!lhit_q) begin
					st_d = ffha_pkg::ST_UNKNOWN;
				end else if (wprev && wnext) begin
					st_d = ffha_pkg::ST_DONE; lv_clr = 1'b1; fcnt_dec = 1'b1;
					dw_we = 1'b1; dw_a = fi_q[FW-1:0] - IDX_ONE; dw_s = ps_q;
					dw_l = pl_q + HDR + HDR + len_q + fl_rd_q; d_shift = 1'b1;
				end else if (wprev) begin
					st_d = ffha_pkg::ST_DONE; lv_clr = 1'b1;
					dw_we = 1'b1; dw_a = fi_q[FW-1:0] - IDX_ONE; dw_s = ps_q;
					dw_l = pl_q + HDR + len_q;
				end else if (wnext) begin
					st_d = ffha_pkg::ST_DONE; lv_clr = 1'b1;
					dw_we = 1'b1; dw_s = off_q; dw_l = fl_rd_q + HDR + len_q;
				end else if (fcnt_q >= (FW+1)'(FREE_SLOTS)) begin
					st_d = ffha_pkg::ST_FULL;
				end else begin
					st_d = ffha_pkg::ST_DONE; lv_clr = 1'b1; fcnt_inc = 1'b1;
					d_shift = 1'b1; sh_up_d = 1'b1; sh_q_d = fcnt_q;
				end
			end
			ffha_pkg::KIND_QUERY: begin
				if (lhit_q) begin
					st_d = ffha_pkg::ST_DONE; us_d = len_q[15:0];
				end
			end
			default: ;
		endcase
	end

	// Shift step: move one entry per read/write pair; the read data is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sh_phase_q <= 1'b0;
		else if (state_q == ffha_pkg::S_SHIFT) sh_phase_q <= ~sh_phase_q;
		else sh_phase_q <= 1'b0;
	end

	always_comb begin
		state_d = state_q;
		fwe = 1'b0; fwa = '0; fws = '0; fwl = '0; fra = fi_q[FW-1:0];
		case (state_q)
			ffha_pkg::S_INIT: begin
				fwe = 1'b1; fwa = sh_q[FW-1:0]; fws = '0;
				fwl = (sh_q == '0) ? INIT_LEN : '0;
				if (sh_q == (FW+1)'(FREE_SLOTS - 1)) state_d = ffha_pkg::S_IDLE;
			end
			ffha_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = ffha_pkg::S_LSCAN;
				end
			end
			ffha_pkg::S_LSCAN: begin
				if (li_q == (LW+1)'(LIVE_SLOTS - 1)) begin
					state_d = (kind_q inside {ffha_pkg::KIND_ALLOC, ffha_pkg::KIND_FREE})
					        ? ffha_pkg::S_FREAD : ffha_pkg::S_DECIDE;
				end
			end
			ffha_pkg::S_FREAD: begin
				fra = fi_q[FW-1:0];
				state_d = fscan_done ? ffha_pkg::S_DECIDE : ffha_pkg::S_FSCAN;
			end
			ffha_pkg::S_FSCAN: begin
				// Stop at first fit (alloc) or first start above the block (free).
				if (kind_q == ffha_pkg::KIND_ALLOC ? (fl_rd_q >= needed_q)
				                                   : (fs_rd_q > off_q)) begin
					state_d = ffha_pkg::S_WRITE;
				end else begin
					state_d = ffha_pkg::S_FREAD;
				end
				fra = fi_q[FW-1:0] - IDX_ONE;
			end
			ffha_pkg::S_WRITE: begin
				fra = fi_q[FW-1:0];
				state_d = ffha_pkg::S_DECIDE;
			end
			ffha_pkg::S_DECIDE: begin
				fwe = dw_we; fwa = dw_a; fws = dw_s; fwl = dw_l;
				if (d_shift && lv_set) state_d = ffha_pkg::S_SHIFT;
				else if (d_shift && lv_clr) state_d = ffha_pkg::S_SHIFT;
				else state_d = ffha_pkg::S_DONE;
				if (!lhit_q && !lv_set) state_d = ffha_pkg::S_DONE;
				if (d_shift && sh_up_d) begin
					// Insert: shift from the top down; the new extent is written last, into slot fi_q.
					state_d = ffha_pkg::S_SHIFT;
				end
			end
			ffha_pkg::S_SHIFT: begin
				// sh_q is the slot being written; source is its neighbor.
				if (sh_up_q) begin
					if (sh_q == fi_q) begin
						fwe = 1'b1; fwa = sh_q[FW-1:0]; fws = off_q; fwl = len_q;
						state_d = ffha_pkg::S_DONE;
					end else begin
						fra = sh_q[FW-1:0] - IDX_ONE;
						fwe = sh_phase_q; fwa = sh_q[FW-1:0]; fws = fs_rd_q; fwl = fl_rd_q;
					end
				end else begin
					if (sh_q >= fcnt_q) begin
						state_d = ffha_pkg::S_DONE;
					end else begin
						fra = sh_q[FW-1:0] + IDX_ONE;
						fwe = sh_phase_q; fwa = sh_q[FW-1:0]; fws = fs_rd_q; fwl = fl_rd_q;
					end
				end
			end
			ffha_pkg::S_DONE: begin
				if (!rvalid_q) state_d = ffha_pkg::S_DONE;
				if (rvalid_q && rsp.ready) state_d = ffha_pkg::S_IDLE;
			end
			default: state_d = ffha_pkg::S_IDLE;
		endcase
	end

	assign req.ready           = (state_q == ffha_pkg::S_IDLE);
	assign rsp.valid           = rvalid_q;
	assign rsp.status          = st_q;
	assign rsp.payload_address = pa_q;
	assign rsp.usable_size     = us_q;

	`CHK_ASSERT(a_busy_no_ready, (rsp.valid |-> !req.ready), "ready while a response waits")
	`CHK_ASSERT(a_fcnt_range, (fcnt_q <= (FW+1)'(FREE_SLOTS)), "free count overflow")
	`CHK_ASSERT(a_rsp_hold, (rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status) && $stable(rsp.payload_address) && $stable(rsp.usable_size)), "response word changed while stalled")
endmodule
